// ===== sv/kalman_filter_update_defines.svh =====
// Assertion macros used by the Kalman filter update RTL.
`ifndef KALMAN_FILTER_UPDATE_DEFINES_SVH
`define KALMAN_FILTER_UPDATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KFU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/kfu_pkg.sv =====
// Types, codes and the step program of the Kalman filter update block.
`timescale 1ns / 1ps

package kfu_pkg;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RDA,
      ST_RDB,
      ST_LDB,
      ST_RUN,
      ST_ACC,
      ST_OUT
   } kfu_state_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_A_MATRIX,
      CSR_C_VECTOR,
      CSR_Q_MATRIX,
      CSR_R_VALUE
   } csr_index_type;

   // Kind of one program step.
   typedef enum logic [1:0] {
      UOP_MAC,
      UOP_DIV,
      UOP_END
   } uop_kind_type;

   // Command to the serial arithmetic unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } arith_cmd_type;

   // One program step: multiply, round, add or subtract; or divide; or end.
   typedef struct packed {
      uop_kind_type kind;
      logic         clr;
      logic         sub;
      logic         sh16;
      logic         wr;
      logic [5:0]   opa;
      logic [5:0]   opb;
      logic [5:0]   dst;
   } uop_type;

   localparam logic SH12 = 1'b0;
   localparam logic SH16 = 1'b1;

   // Operand codes: fixed sources below 32, scratch memory entries from 32 up.
   localparam logic [5:0] OP_A00    = 6'd0;
   localparam logic [5:0] OP_A01    = 6'd1;
   localparam logic [5:0] OP_A10    = 6'd2;
   localparam logic [5:0] OP_A11    = 6'd3;
   localparam logic [5:0] OP_C0     = 6'd4;
   localparam logic [5:0] OP_C1     = 6'd5;
   localparam logic [5:0] OP_Q00    = 6'd6;
   localparam logic [5:0] OP_Q01    = 6'd7;
   localparam logic [5:0] OP_Q10    = 6'd8;
   localparam logic [5:0] OP_Q11    = 6'd9;
   localparam logic [5:0] OP_R      = 6'd10;
   localparam logic [5:0] OP_Z      = 6'd11;
   localparam logic [5:0] OP_K4096  = 6'd12;
   localparam logic [5:0] OP_K8192  = 6'd13;
   localparam logic [5:0] OP_K65536 = 6'd14;
   localparam logic [5:0] OP_X0     = 6'd15;
   localparam logic [5:0] OP_X1     = 6'd16;
   localparam logic [5:0] OP_P00    = 6'd17;
   localparam logic [5:0] OP_P01    = 6'd18;
   localparam logic [5:0] OP_P10    = 6'd19;
   localparam logic [5:0] OP_P11    = 6'd20;
   localparam logic [5:0] OP_NONE   = 6'd31;
   localparam logic [5:0] OP_XP0    = 6'd32;
   localparam logic [5:0] OP_XP1    = 6'd33;
   localparam logic [5:0] OP_T00    = 6'd34;
   localparam logic [5:0] OP_T01    = 6'd35;
   localparam logic [5:0] OP_T10    = 6'd36;
   localparam logic [5:0] OP_T11    = 6'd37;
   localparam logic [5:0] OP_PP00   = 6'd38;
   localparam logic [5:0] OP_PP01   = 6'd39;
   localparam logic [5:0] OP_PP10   = 6'd40;
   localparam logic [5:0] OP_PP11   = 6'd41;
   localparam logic [5:0] OP_PC0    = 6'd42;
   localparam logic [5:0] OP_PC1    = 6'd43;
   localparam logic [5:0] OP_S      = 6'd44;
   localparam logic [5:0] OP_K0     = 6'd45;
   localparam logic [5:0] OP_K1     = 6'd46;
   localparam logic [5:0] OP_CX     = 6'd47;
   localparam logic [5:0] OP_Y      = 6'd48;
   localparam logic [5:0] OP_M00    = 6'd49;
   localparam logic [5:0] OP_M01    = 6'd50;
   localparam logic [5:0] OP_M10    = 6'd51;
   localparam logic [5:0] OP_M11    = 6'd52;
   localparam logic [5:0] OP_U00    = 6'd53;
   localparam logic [5:0] OP_U01    = 6'd54;
   localparam logic [5:0] OP_U10    = 6'd55;
   localparam logic [5:0] OP_U11    = 6'd56;
   localparam logic [5:0] OP_V00    = 6'd57;
   localparam logic [5:0] OP_V01    = 6'd58;
   localparam logic [5:0] OP_V10    = 6'd59;
   localparam logic [5:0] OP_V11    = 6'd60;
   localparam logic [5:0] OP_KR0    = 6'd61;
   localparam logic [5:0] OP_KR1    = 6'd62;

   localparam int SCRATCH_DEPTH = 32;

   function automatic uop_type mac(input logic clr, input logic sub, input logic sh16,
                                   input logic [5:0] opa, input logic [5:0] opb,
                                   input logic wr, input logic [5:0] dst);
      uop_type u;
      u.kind = UOP_MAC;
      u.clr  = clr;
      u.sub  = sub;
      u.sh16 = sh16;
      u.wr   = wr;
      u.opa  = opa;
      u.opb  = opb;
      u.dst  = dst;
      return u;
   endfunction

   // First term of a sum: clears the accumulator, no write.
   function automatic uop_type first(input logic [5:0] opa, input logic [5:0] opb,
                                     input logic sh16);
      return mac(1'b1, 1'b0, sh16, opa, opb, 1'b0, OP_NONE);
   endfunction

   // Last term of a sum: accumulates and writes the saturated total.
   function automatic uop_type last(input logic [5:0] opa, input logic [5:0] opb,
                                    input logic sh16, input logic [5:0] dst);
      return mac(1'b0, 1'b0, sh16, opa, opb, 1'b1, dst);
   endfunction

   function automatic uop_type mid(input logic [5:0] opa, input logic [5:0] opb,
                                   input logic sh16);
      return mac(1'b0, 1'b0, sh16, opa, opb, 1'b0, OP_NONE);
   endfunction

   function automatic uop_type divop(input logic [5:0] num, input logic [5:0] den,
                                     input logic [5:0] dst);
      uop_type u;
      u      = mac(1'b1, 1'b0, SH12, num, den, 1'b1, dst);
      u.kind = UOP_DIV;
      return u;
   endfunction

   function automatic uop_type endop();
      uop_type u;
      u      = mac(1'b0, 1'b0, SH12, OP_NONE, OP_NONE, 1'b0, OP_NONE);
      u.kind = UOP_END;
      return u;
   endfunction

   // The full update as a list of steps.
   function automatic uop_type uop_at(input logic [6:0] step);
      uop_type u;
      case (step)
         // Predicted state.
         7'd0:  u = first(OP_A00, OP_X0, SH12);
         7'd1:  u = last(OP_A01, OP_X1, SH12, OP_XP0);
         7'd2:  u = first(OP_A10, OP_X0, SH12);
         7'd3:  u = last(OP_A11, OP_X1, SH12, OP_XP1);
         // A times P.
         7'd4:  u = first(OP_A00, OP_P00, SH12);
         7'd5:  u = last(OP_A01, OP_P10, SH12, OP_T00);
         7'd6:  u = first(OP_A00, OP_P01, SH12);
         7'd7:  u = last(OP_A01, OP_P11, SH12, OP_T01);
         7'd8:  u = first(OP_A10, OP_P00, SH12);
         7'd9:  u = last(OP_A11, OP_P10, SH12, OP_T10);
         7'd10: u = first(OP_A10, OP_P01, SH12);
         7'd11: u = last(OP_A11, OP_P11, SH12, OP_T11);
         // Predicted covariance, Q entries doubled.
         7'd12: u = first(OP_Q00, OP_K8192, SH12);
         7'd13: u = mid(OP_T00, OP_A00, SH12);
         7'd14: u = last(OP_T01, OP_A01, SH12, OP_PP00);
         7'd15: u = first(OP_Q01, OP_K8192, SH12);
         7'd16: u = mid(OP_T00, OP_A10, SH12);
         7'd17: u = last(OP_T01, OP_A11, SH12, OP_PP01);
         7'd18: u = first(OP_Q10, OP_K8192, SH12);
         7'd19: u = mid(OP_T10, OP_A00, SH12);
         7'd20: u = last(OP_T11, OP_A01, SH12, OP_PP10);
         7'd21: u = first(OP_Q11, OP_K8192, SH12);
         7'd22: u = mid(OP_T10, OP_A10, SH12);
         7'd23: u = last(OP_T11, OP_A11, SH12, OP_PP11);
         // P' C^T.
         7'd24: u = first(OP_PP00, OP_C0, SH12);
         7'd25: u = last(OP_PP01, OP_C1, SH12, OP_PC0);
         7'd26: u = first(OP_PP10, OP_C0, SH12);
         7'd27: u = last(OP_PP11, OP_C1, SH12, OP_PC1);
         // Innovation variance.
         7'd28: u = first(OP_R, OP_K4096, SH12);
         7'd29: u = mid(OP_C0, OP_PC0, SH12);
         7'd30: u = last(OP_C1, OP_PC1, SH12, OP_S);
         // Gain.
         7'd31: u = divop(OP_PC0, OP_S, OP_K0);
         7'd32: u = divop(OP_PC1, OP_S, OP_K1);
         // Innovation.
         7'd33: u = first(OP_C0, OP_XP0, SH12);
         7'd34: u = last(OP_C1, OP_XP1, SH12, OP_CX);
         7'd35: u = first(OP_Z, OP_K4096, SH12);
         7'd36: u = mac(1'b0, 1'b1, SH12, OP_CX, OP_K4096, 1'b1, OP_Y);
         // I - K C.
         7'd37: u = first(OP_K65536, OP_K4096, SH12);
         7'd38: u = mac(1'b0, 1'b1, SH12, OP_K0, OP_C0, 1'b1, OP_M00);
         7'd39: u = mac(1'b1, 1'b1, SH12, OP_K0, OP_C1, 1'b1, OP_M01);
         7'd40: u = mac(1'b1, 1'b1, SH12, OP_K1, OP_C0, 1'b1, OP_M10);
         7'd41: u = first(OP_K65536, OP_K4096, SH12);
         7'd42: u = mac(1'b0, 1'b1, SH12, OP_K1, OP_C1, 1'b1, OP_M11);
         // (I-KC) P'.
         7'd43: u = first(OP_M00, OP_PP00, SH16);
         7'd44: u = last(OP_M01, OP_PP10, SH16, OP_U00);
         7'd45: u = first(OP_M00, OP_PP01, SH16);
         7'd46: u = last(OP_M01, OP_PP11, SH16, OP_U01);
         7'd47: u = first(OP_M10, OP_PP00, SH16);
         7'd48: u = last(OP_M11, OP_PP10, SH16, OP_U10);
         7'd49: u = first(OP_M10, OP_PP01, SH16);
         7'd50: u = last(OP_M11, OP_PP11, SH16, OP_U11);
         // (I-KC) P' (I-KC)^T.
         7'd51: u = first(OP_U00, OP_M00, SH16);
         7'd52: u = last(OP_U01, OP_M01, SH16, OP_V00);
         7'd53: u = first(OP_U00, OP_M10, SH16);
         7'd54: u = last(OP_U01, OP_M11, SH16, OP_V01);
         7'd55: u = first(OP_U10, OP_M00, SH16);
         7'd56: u = last(OP_U11, OP_M01, SH16, OP_V10);
         7'd57: u = first(OP_U10, OP_M10, SH16);
         7'd58: u = last(OP_U11, OP_M11, SH16, OP_V11);
         // K R.
         7'd59: u = mac(1'b1, 1'b0, SH16, OP_K0, OP_R, 1'b1, OP_KR0);
         7'd60: u = mac(1'b1, 1'b0, SH16, OP_K1, OP_R, 1'b1, OP_KR1);
         // Corrected state.
         7'd61: u = first(OP_XP0, OP_K4096, SH12);
         7'd62: u = last(OP_K0, OP_Y, SH16, OP_X0);
         7'd63: u = first(OP_XP1, OP_K4096, SH12);
         7'd64: u = last(OP_K1, OP_Y, SH16, OP_X1);
         // Corrected covariance.
         7'd65: u = first(OP_V00, OP_K4096, SH12);
         7'd66: u = last(OP_KR0, OP_K0, SH16, OP_P00);
         7'd67: u = first(OP_V01, OP_K4096, SH12);
         7'd68: u = last(OP_KR0, OP_K1, SH16, OP_P01);
         7'd69: u = first(OP_V10, OP_K4096, SH12);
         7'd70: u = last(OP_KR1, OP_K0, SH16, OP_P10);
         7'd71: u = first(OP_V11, OP_K4096, SH12);
         7'd72: u = last(OP_KR1, OP_K1, SH16, OP_P11);
         default: u = endop();
      endcase
      return u;
   endfunction

endpackage

// ===== sv/kfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kfu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/kfu_arith.sv =====
// Shared digit-serial multiplier (4 bits per cycle) and bit-serial divider.
`timescale 1ns / 1ps

module kfu_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  kfu_pkg::arith_cmd_type cmd,
   input  logic signed [32:0]     opa,
   input  logic signed [32:0]     opb,
   output logic                   done,
   output logic signed [66:0]     prod,
   output logic signed [31:0]     quot
);

   import kfu_pkg::*;

   localparam logic [5:0] MUL_STEPS = 6'd9;
   localparam logic [5:0] DIV_STEPS = 6'd48;

   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [32:0] amag_ff, amag_in;
   logic [33:0] hi_ff, hi_in;
   logic [35:0] lo_ff, lo_in;
   logic [31:0] dmag_ff, dmag_in;
   logic [31:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;

   logic [32:0] abs_a, abs_b;
   logic [36:0] part;
   logic [37:0] msum;
   logic [33:0] trial;
   logic [66:0] mag;

   assign abs_a = opa[32] ? (~opa + 33'd1) : opa;
   assign abs_b = opb[32] ? (~opb + 33'd1) : opb;

   // One multiplier digit and one divider bit per cycle.
   assign part  = {4'd0, amag_ff} * {33'd0, lo_ff[3:0]};
   assign msum  = {4'd0, hi_ff} + {1'b0, part};
   assign trial = {1'b0, rem_ff, quo_ff[47]} - {2'd0, dmag_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      amag_in = amag_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         div_in  = cmd.is_div;
         neg_in  = opa[32] ^ opb[32];
         amag_in = abs_a;
         hi_in   = '0;
         lo_in   = {3'd0, abs_b};
         dmag_in = abs_b[31:0];
         rem_in  = '0;
         quo_in  = {abs_a[31:0], 16'd0};
         cnt_in  = cmd.is_div ? DIV_STEPS : MUL_STEPS;
      end else if (cnt_ff != 6'd0) begin
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
         if (div_ff) begin
            rem_in = trial[33] ? {rem_ff[30:0], quo_ff[47]} : trial[31:0];
            quo_in = {quo_ff[46:0], ~trial[33]};
         end else begin
            hi_in = msum[37:4];
            lo_in = {msum[3:0], lo_ff[35:4]};
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      amag_ff <= amag_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // Signed product and saturated quotient.
   assign mag = {1'b0, hi_ff[29:0], lo_ff};

   always_comb begin
      prod = neg_ff ? signed'(~mag + 67'd1) : signed'(mag);
      if (!neg_ff) begin
         quot = (quo_ff > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(quo_ff[31:0]);
      end else begin
         quot = (quo_ff > 48'h0000_8000_0000) ? 32'sh8000_0000
                                              : signed'(~quo_ff[31:0] + 32'd1);
      end
   end

   assign done = done_ff;

endmodule

// ===== sv/kalman_filter_update.sv =====
// Top level of the fixed-point two-state Kalman filter update block.
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_tvalid / req_tready   | tdata[31:0] measurement
//  rsp     | out       | rsp_tvalid / rsp_tready   | tdata estimates, tuser singular
//  csr     | in        | csr_wr_en                 | csr_index, csr_wr_data
//
// An item runs through a 73-step program on one shared serial unit: a multiply
// goes through operand fetch from the scratch RAM, 9 digits of 4 bits and write
// back, and each of the two gain divisions forms 48 quotient bits.
// A zero innovation variance ends the update as soon as it is written back.
// Reset is synchronous and restores x = 0 and P = identity.
// A new word is taken while a finished result waits on a stalled rsp channel.
`timescale 1ns / 1ps
`include "kalman_filter_update_defines.svh"

module kalman_filter_update (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] measurement
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] estimate_first, [63:32] estimate_second
   output logic        rsp_tuser,   // [0] singular
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   import kfu_pkg::*;

   kfu_state_type      state_ff, state_in;
   logic [6:0]         step_ff, step_in;
   logic signed [56:0] acc_ff, acc_in;
   logic signed [32:0] opa_ff, opa_in;
   logic [31:0]        z_ff, z_in;
   logic               singular_ff, singular_in;
   logic [63:0]        a_ff, a_in, q_ff, q_in;
   logic [31:0]        c_ff, c_in, r_ff, r_in;
   logic [31:0]        x0_ff, x0_in, x1_ff, x1_in;
   logic [31:0]        p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_user_ff, rsp_user_in;

   uop_type            uop;
   logic [5:0]         cur_code;
   logic signed [32:0] opnd_val;
   logic               ram_we;
   logic [4:0]         ram_raddr;
   logic [31:0]        ram_wdata, ram_rdata;
   arith_cmd_type      arith_cmd;
   logic               arith_done;
   logic signed [66:0] arith_prod;
   logic signed [31:0] arith_quot;
   logic signed [66:0] rsum, rshift;
   logic signed [56:0] term, base, acc_sum;
   logic [31:0]        wr_val;

   function automatic logic [31:0] sat57(input logic signed [56:0] v);
      logic [31:0] r;
      if (v > 57'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -57'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [32:0] sx16(input logic [15:0] v);
      return signed'({{17{v[15]}}, v});
   endfunction

   function automatic logic signed [32:0] sx32(input logic [31:0] v);
      return signed'({v[31], v});
   endfunction

   assign uop = uop_at(step_ff);

   // Operand select: the A operand is latched in RDB, the B operand used in LDB.
   assign cur_code  = (state_ff == ST_RDB) ? uop.opa : uop.opb;
   assign ram_raddr = (state_ff == ST_RDA) ? uop.opa[4:0] : uop.opb[4:0];

   always_comb begin
      case (cur_code)
         OP_A00:    opnd_val = sx16(a_ff[15:0]);
         OP_A01:    opnd_val = sx16(a_ff[31:16]);
         OP_A10:    opnd_val = sx16(a_ff[47:32]);
         OP_A11:    opnd_val = sx16(a_ff[63:48]);
         OP_C0:     opnd_val = sx16(c_ff[15:0]);
         OP_C1:     opnd_val = sx16(c_ff[31:16]);
         OP_Q00:    opnd_val = sx16(q_ff[15:0]);
         OP_Q01:    opnd_val = sx16(q_ff[31:16]);
         OP_Q10:    opnd_val = sx16(q_ff[47:32]);
         OP_Q11:    opnd_val = sx16(q_ff[63:48]);
         OP_R:      opnd_val = signed'({1'b0, r_ff});
         OP_Z:      opnd_val = sx32(z_ff);
         OP_K4096:  opnd_val = 33'sd4096;
         OP_K8192:  opnd_val = 33'sd8192;
         OP_K65536: opnd_val = 33'sd65536;
         OP_X0:     opnd_val = sx32(x0_ff);
         OP_X1:     opnd_val = sx32(x1_ff);
         OP_P00:    opnd_val = sx32(p00_ff);
         OP_P01:    opnd_val = sx32(p01_ff);
         OP_P10:    opnd_val = sx32(p10_ff);
         OP_P11:    opnd_val = sx32(p11_ff);
         default:   opnd_val = sx32(ram_rdata);
      endcase
   end

   // Round the product half up at the Q point and add it to or subtract it from the accumulator.
   assign rsum    = arith_prod + (uop.sh16 ? 67'sd32768 : 67'sd2048);
   assign rshift  = uop.sh16 ? (rsum >>> 16) : (rsum >>> 12);
   assign term    = signed'(rshift[56:0]);
   assign base    = uop.clr ? 57'sd0 : acc_ff;
   assign acc_sum = uop.sub ? (base - term) : (base + term);
   assign wr_val  = (uop.kind == UOP_DIV) ? arith_quot : sat57(acc_sum);

   // Next state and datapath.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      acc_in       = acc_ff;
      opa_in       = opa_ff;
      z_in         = z_ff;
      singular_in  = singular_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      p00_in       = p00_ff;
      p01_in       = p01_ff;
      p10_in       = p10_ff;
      p11_in       = p11_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_wdata    = wr_val;
      arith_cmd    = '0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               z_in        = req_tdata;
               step_in     = '0;
               singular_in = 1'b0;
               state_in    = ST_RDA;
            end
         end
         ST_RDA: begin
            state_in = (uop.kind == UOP_END) ? ST_OUT : ST_RDB;
         end
         ST_RDB: begin
            opa_in   = opnd_val;
            state_in = ST_LDB;
         end
         ST_LDB: begin
            arith_cmd.start  = 1'b1;
            arith_cmd.is_div = (uop.kind == UOP_DIV);
            state_in         = ST_RUN;
         end
         ST_RUN: begin
            if (arith_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            acc_in   = acc_sum;
            step_in  = step_ff + 7'd1;
            state_in = ST_RDA;
            if (uop.wr) begin
               ram_we = uop.dst[5];
               case (uop.dst)
                  OP_X0:   x0_in  = wr_val;
                  OP_X1:   x1_in  = wr_val;
                  OP_P00:  p00_in = wr_val;
                  OP_P01:  p01_in = wr_val;
                  OP_P10:  p10_in = wr_val;
                  OP_P11:  p11_in = wr_val;
                  default: ;
               endcase
               // Zero innovation variance skips the update.
               if (uop.dst == OP_S && wr_val == 32'd0) begin
                  singular_in = 1'b1;
                  state_in    = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {x1_ff, x0_ff};
               rsp_user_in  = singular_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Register writes.
      if (csr_wr_en) begin
         case (csr_index)
            CSR_A_MATRIX: a_in = csr_wr_data;
            CSR_C_VECTOR: c_in = csr_wr_data[31:0];
            CSR_Q_MATRIX: q_in = csr_wr_data;
            CSR_R_VALUE:  r_in = csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control, configuration and filter state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         a_ff         <= '0;
         c_ff         <= '0;
         q_ff         <= '0;
         r_ff         <= 32'd65536;
         x0_ff        <= '0;
         x1_ff        <= '0;
         p00_ff       <= 32'd65536;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= 32'd65536;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         a_ff         <= a_in;
         c_ff         <= c_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         x0_ff        <= x0_in;
         x1_ff        <= x1_in;
         p00_ff       <= p00_in;
         p01_ff       <= p01_in;
         p10_ff       <= p10_in;
         p11_ff       <= p11_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      opa_ff      <= opa_in;
      z_ff        <= z_in;
      singular_ff <= singular_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Scratch values of one update.
   kfu_ram #(
      .WIDTH (32),
      .DEPTH (SCRATCH_DEPTH)
   ) u_scratch (
      .clock (clock),
      .we    (ram_we),
      .waddr (uop.dst[4:0]),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   kfu_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .opa   (opa_ff),
      .opb   (opnd_val),
      .done  (arith_done),
      .prod  (arith_prod),
      .quot  (arith_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // The serial unit finishes only while the sequencer waits for it.
   `KFU_ASSERT_NOW(a_done_in_run, clock, reset, arith_done, state_ff == ST_RUN,
      "arithmetic unit finished outside the run state")

   // The program counter moves only on a write back or a new word.
   `KFU_ASSERT_NEXT(a_step_hold, clock, reset,
      (state_ff != ST_ACC) && (state_ff != ST_IDLE), $stable(step_ff),
      "step counter moved outside write back")

   // An accepted word starts the program at once.
   `KFU_ASSERT_NEXT(a_start, clock, reset, req_tvalid && req_tready,
      (state_ff == ST_RDA) && (step_ff == 7'd0), "accepted word did not start the program")

endmodule
